// ===== hdl/wfts_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame-time statistics package
// Shared widths, defaults, the sequencer state type and the status type of
// the iterative arithmetic units.
// ----------------------------------------------------------------------------
package wfts_pkg;

  localparam int unsigned SAMPLE_W       = 20;
  localparam int unsigned COUNT_OUT_W    = 8;
  localparam int unsigned RING_DEPTH_DEF = 128;
  localparam int unsigned MIN_HITCH_CNT  = 10;
  localparam int unsigned ROOT_W         = SAMPLE_W;
  localparam int unsigned VAR_W          = 2 * ROOT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SQ_NEW,
    ST_SQ_OLD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SS,
    ST_MUL_NN,
    ST_DIV_MEAN,
    ST_DIV_VAR,
    ST_SQRT,
    ST_FINISH
  } wfts_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } wfts_unit_sts_t;

endpackage

// ===== hdl/wfts_div.sv =====
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring shift-and-subtract divider, one quotient bit per cycle. The done
// flag stays high from the last step until the next start.
// ----------------------------------------------------------------------------
module wfts_div #(
  parameter int unsigned DVD_W = 56,
  parameter int unsigned DVS_W = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DVD_W-1:0]       dividend_i,
  input  logic [DVS_W-1:0]       divisor_i,
  output logic [DVD_W-1:0]       quotient_o,
  output wfts_pkg::wfts_unit_sts_t sts_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_nx;
  logic              fits;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(DVD_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= rem_nx[DVS_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== hdl/wfts_isqrt.sv =====
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit root, two radicand bits and one root bit per cycle. The done
// flag stays high from the last step until the next start.
// ----------------------------------------------------------------------------
module wfts_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wfts_pkg::VAR_W-1:0]     radicand_i,
  output logic [wfts_pkg::ROOT_W-1:0]    root_o,
  output wfts_pkg::wfts_unit_sts_t       sts_o
);

  localparam int unsigned RW     = wfts_pkg::ROOT_W;
  localparam int unsigned VW     = wfts_pkg::VAR_W;
  localparam int unsigned STEP_W = $clog2(RW + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [VW-1:0]     rad_q;
  logic [RW:0]       rem_q;
  logic [RW-1:0]     root_q;

  logic [RW+1:0]     rem_sh;
  logic [RW+1:0]     trial;
  logic [RW+1:0]     rem_nx;
  logic              fits;

  assign rem_sh = {rem_q[RW-1:0], rad_q[VW-1:VW-2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = rem_sh >= trial;
  assign rem_nx = fits ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(RW);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[VW-3:0], 2'b00};
      rem_q  <= rem_nx[RW:0];
      root_q <= {root_q[RW-2:0], fits};
    end
  end

  assign root_o     = root_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== hdl/window_frame_time_statistics.sv =====
// ----------------------------------------------------------------------------
// Sliding-window frame-time statistics
// Keeps the last RING_DEPTH samples in a ring memory and reports count, mean,
// standard deviation and the number of samples above twice the mean.
//
// One sample is taken while the sequencer is idle; a finished result waits in
// the output register and does not hold off the next sample. The mean and the
// variance go one after the other through one bit-serial divider on
// NUM_W = 40 + 2*ceil(log2(RING_DEPTH+1)) bits, then through a bit-serial
// square root. The hitch count walks the held samples over the single read
// port of the ring, one entry a cycle alongside the arithmetic, and reads zero
// while fewer than MIN_HITCH_CNT samples are held. The result waits in
// ST_FINISH until the walk has ended. No clearing pass follows reset:
// unwritten ring entries may be read, but their data is never used.
// ----------------------------------------------------------------------------
module window_frame_time_statistics #(
  parameter int unsigned RING_DEPTH = wfts_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [wfts_pkg::SAMPLE_W-1:0]      sample_us_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [wfts_pkg::COUNT_OUT_W-1:0]   sample_count_o,
  output logic [wfts_pkg::SAMPLE_W-1:0]      mean_us_o,
  output logic [wfts_pkg::SAMPLE_W-1:0]      stddev_us_o,
  output logic [wfts_pkg::COUNT_OUT_W-1:0]   hitch_count_o
);

  localparam int unsigned SW     = wfts_pkg::SAMPLE_W;
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W  = SW + CNT_W;
  localparam int unsigned SQ_W   = 2 * SW + CNT_W;
  localparam int unsigned NUM_W  = 2 * SUM_W;
  localparam int unsigned DVS_W  = 2 * CNT_W;

  wfts_pkg::wfts_state_e state_q, state_d;

  logic [SW-1:0]     ring_mem [RING_DEPTH];
  logic [SW-1:0]     rdata_q;
  logic              mem_rd;
  logic [ADDR_W-1:0] mem_raddr;

  logic [ADDR_W-1:0] slot_q;
  logic [CNT_W-1:0]  fill_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sq_q;
  logic              full;
  logic [SW-1:0]     evict;
  logic [CNT_W-1:0]  fill_d;

  logic [SW-1:0]     s_q;
  logic [SW-1:0]     old_q;
  logic [NUM_W-1:0]  prod_q;
  logic [NUM_W-1:0]  acc_q;
  logic [NUM_W-1:0]  num_q;
  logic [SW-1:0]     mean_q;
  logic [SUM_W-1:0]  mul_a;
  logic [SUM_W-1:0]  mul_b;

  logic              fsm_rd;
  logic              ring_wr;
  logic              mul_en;
  logic              div_start;
  logic              div_var;
  logic              sqrt_start;
  logic              out_load;

  logic [NUM_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [NUM_W-1:0]  div_quo;
  logic [wfts_pkg::ROOT_W-1:0] root;
  wfts_pkg::wfts_unit_sts_t    div_sts;
  wfts_pkg::wfts_unit_sts_t    sqrt_sts;

  logic              scan_act_q;
  logic              scan_v1_q;
  logic              scan_v2_q;
  logic [CNT_W-1:0]  scan_cnt_q;
  logic [SUM_W-1:0]  scan_prod_q;
  logic [CNT_W-1:0]  hitch_q;
  logic              scan_busy;

  logic              out_valid_q;
  logic [wfts_pkg::COUNT_OUT_W-1:0] out_count_q;
  logic [SW-1:0]                    out_mean_q;
  logic [SW-1:0]                    out_sd_q;
  logic [wfts_pkg::COUNT_OUT_W-1:0] out_hitch_q;

  assign full      = fill_q == CNT_W'(RING_DEPTH);
  assign evict     = full ? rdata_q : '0;
  assign fill_d    = full ? fill_q : (fill_q + CNT_W'(1));
  assign scan_busy = scan_act_q | scan_v1_q | scan_v2_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wfts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    fsm_rd     = 1'b0;
    ring_wr    = 1'b0;
    mul_en     = 1'b0;
    div_start  = 1'b0;
    div_var    = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      wfts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          fsm_rd  = 1'b1;
          state_d = wfts_pkg::ST_EVICT;
        end
      end
      wfts_pkg::ST_EVICT: begin
        ring_wr = 1'b1;
        mul_en  = 1'b1;
        state_d = wfts_pkg::ST_SQ_NEW;
      end
      wfts_pkg::ST_SQ_NEW: begin
        mul_en  = 1'b1;
        state_d = wfts_pkg::ST_SQ_OLD;
      end
      wfts_pkg::ST_SQ_OLD: begin
        div_start = 1'b1;
        state_d   = wfts_pkg::ST_MUL_LO;
      end
      wfts_pkg::ST_MUL_LO: begin
        mul_en  = 1'b1;
        state_d = wfts_pkg::ST_MUL_HI;
      end
      wfts_pkg::ST_MUL_HI: begin
        mul_en  = 1'b1;
        state_d = wfts_pkg::ST_MUL_SS;
      end
      wfts_pkg::ST_MUL_SS: begin
        mul_en  = 1'b1;
        state_d = wfts_pkg::ST_MUL_NN;
      end
      wfts_pkg::ST_MUL_NN: begin
        mul_en  = 1'b1;
        state_d = wfts_pkg::ST_DIV_MEAN;
      end
      wfts_pkg::ST_DIV_MEAN: begin
        if (div_sts.done) begin
          div_start = 1'b1;
          div_var   = 1'b1;
          state_d   = wfts_pkg::ST_DIV_VAR;
        end
      end
      wfts_pkg::ST_DIV_VAR: begin
        if (div_sts.done) begin
          sqrt_start = 1'b1;
          state_d    = wfts_pkg::ST_SQRT;
        end
      end
      wfts_pkg::ST_SQRT: begin
        if (sqrt_sts.done) begin
          state_d = wfts_pkg::ST_FINISH;
        end
      end
      wfts_pkg::ST_FINISH: begin
        if (!scan_busy && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          state_d  = wfts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wfts_pkg::ST_IDLE;
      end
    endcase
  end

  // Ring memory
  assign mem_rd    = fsm_rd | scan_act_q;
  assign mem_raddr = scan_act_q ? scan_cnt_q[ADDR_W-1:0] : slot_q;

  always_ff @(posedge clk_i) begin
    if (ring_wr) begin
      ring_mem[slot_q] <= s_q;
    end
    if (mem_rd) begin
      rdata_q <= ring_mem[mem_raddr];
    end
  end

  // Window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
    end else begin
      if (state_q == wfts_pkg::ST_EVICT) begin
        sum_q  <= sum_q + SUM_W'(s_q) - SUM_W'(evict);
        fill_q <= fill_d;
        slot_q <= (slot_q == ADDR_W'(RING_DEPTH - 1)) ? '0 : (slot_q + ADDR_W'(1));
      end
      if (state_q == wfts_pkg::ST_SQ_NEW) begin
        sq_q <= sq_q + SQ_W'(prod_q);
      end
      if (state_q == wfts_pkg::ST_SQ_OLD) begin
        sq_q <= sq_q - SQ_W'(prod_q);
      end
    end
  end

  // Shared multiplier
  always_comb begin
    unique case (state_q)
      wfts_pkg::ST_EVICT: begin
        mul_a = SUM_W'(s_q);
        mul_b = SUM_W'(s_q);
      end
      wfts_pkg::ST_SQ_NEW: begin
        mul_a = SUM_W'(old_q);
        mul_b = SUM_W'(old_q);
      end
      wfts_pkg::ST_MUL_LO: begin
        mul_a = sq_q[SUM_W-1:0];
        mul_b = SUM_W'(fill_q);
      end
      wfts_pkg::ST_MUL_HI: begin
        mul_a = SUM_W'(sq_q[SQ_W-1:SUM_W]);
        mul_b = SUM_W'(fill_q);
      end
      wfts_pkg::ST_MUL_SS: begin
        mul_a = sum_q;
        mul_b = sum_q;
      end
      wfts_pkg::ST_MUL_NN: begin
        mul_a = SUM_W'(fill_q);
        mul_b = SUM_W'(fill_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == wfts_pkg::ST_IDLE && in_valid_i) begin
      s_q <= sample_us_i;
    end
    if (state_q == wfts_pkg::ST_EVICT) begin
      old_q <= evict;
    end
    if (mul_en) begin
      prod_q <= NUM_W'(mul_a) * NUM_W'(mul_b);
    end
    if (state_q == wfts_pkg::ST_MUL_HI) begin
      acc_q <= prod_q;
    end
    if (state_q == wfts_pkg::ST_MUL_SS) begin
      acc_q <= acc_q + (prod_q << SUM_W);
    end
    if (state_q == wfts_pkg::ST_MUL_NN) begin
      num_q <= acc_q - prod_q;
    end
    if (state_q == wfts_pkg::ST_DIV_MEAN && div_sts.done) begin
      mean_q <= div_quo[SW-1:0];
    end
  end

  // Divide: mean first, then variance by count squared
  assign div_dvd = div_var ? num_q : NUM_W'(sum_q);
  assign div_dvs = div_var ? prod_q[DVS_W-1:0] : DVS_W'(fill_q);

  wfts_div #(
    .DVD_W (NUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .sts_o      (div_sts)
  );

  wfts_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quo[wfts_pkg::VAR_W-1:0]),
    .root_o     (root),
    .sts_o      (sqrt_sts)
  );

  // Hitch scan over held samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q <= 1'b0;
      scan_v1_q  <= 1'b0;
      scan_v2_q  <= 1'b0;
      scan_cnt_q <= '0;
    end else begin
      scan_v1_q <= scan_act_q;
      scan_v2_q <= scan_v1_q;
      if (state_q == wfts_pkg::ST_EVICT) begin
        scan_act_q <= fill_d >= CNT_W'(wfts_pkg::MIN_HITCH_CNT);
        scan_cnt_q <= '0;
      end else if (scan_act_q) begin
        scan_cnt_q <= scan_cnt_q + CNT_W'(1);
        if (scan_cnt_q == fill_q - CNT_W'(1)) begin
          scan_act_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_v1_q) begin
      scan_prod_q <= SUM_W'(rdata_q) * SUM_W'(fill_q);
    end
    if (state_q == wfts_pkg::ST_EVICT) begin
      hitch_q <= '0;
    end else if (scan_v2_q && ({1'b0, scan_prod_q} > {sum_q, 1'b0})) begin
      hitch_q <= hitch_q + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= wfts_pkg::COUNT_OUT_W'(fill_q);
      out_mean_q  <= mean_q;
      out_sd_q    <= root;
      out_hitch_q <= wfts_pkg::COUNT_OUT_W'(hitch_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_count_o = out_count_q;
  assign mean_us_o      = out_mean_q;
  assign stddev_us_o    = out_sd_q;
  assign hitch_count_o  = out_hitch_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_empty_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (sum_q == '0 && sq_q == '0))
    else $error("running sums not zero with empty window");

  a_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wfts_pkg::ST_IDLE) |-> !scan_busy)
    else $error("ring scan still running while idle");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_act_q |-> (scan_cnt_q < fill_q))
    else $error("ring scan reads beyond held samples");

  a_hitch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (hitch_q <= fill_q))
    else $error("hitch count exceeds sample count");

endmodule
